[hdl/idle_framed_receive_ring_top_assert.svh]
// Assertion macros for the blocks of the idle framed receive ring; ifrr_back includes them.
// Every macro takes a label, the clock and the active-low reset.
`ifndef IDLE_FRAMED_RECEIVE_RING_TOP_ASSERT_SVH
`define IDLE_FRAMED_RECEIVE_RING_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFRR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never be true.
`define IFRR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[hdl/ifrr_pkg.sv]
package ifrr_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 768;
  localparam int unsigned RING_BYTES_DEF  = 1024;
  localparam int unsigned CMDQ_DEPTH_DEF  = 2;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned FLEN_W   = 10;
  localparam int unsigned LEN_W    = 16;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_COMMIT,
    CMD_OPEN,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [BYTE_W-1:0]   rx_byte;
    logic [LIMIT_W-1:0]  read_limit;
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED       = 4'd0,
    ST_OVERFLOW     = 4'd1,
    ST_COMMITTED    = 4'd2,
    ST_DROPPED      = 4'd3,
    ST_NONE_PENDING = 4'd4,
    ST_OPENED       = 4'd5,
    ST_RING_RESET   = 4'd6,
    ST_DATA         = 4'd7,
    ST_NOTHING_OPEN = 4'd8
  } status_e;

  typedef struct packed {
    logic               done;
    status_e            status;
    logic [BYTE_W-1:0]  data_byte;
    logic [FLEN_W-1:0]  frame_length;
    logic               last_byte;
  } result_t;

endpackage

[hdl/idle_framed_receive_ring_top.sv]
// Channel   Direction  Handshake                     Payload
// request   in         start_i high, busy_o low      opcode_i, rx_byte_i, read_limit_i
// result    out        done_o high for one cycle     status_o, data_byte_o,
//                                                    frame_length_o, last_byte_o
//
// An accepted request is held in the front register, then sits in the command
// queue until the execution engine is idle. A store, a dropped commit and an
// open or read that finds nothing end in the idle state; a read goes to S_RD,
// an open to its header states, a commit to S_HDR_HI and S_COPY, one byte per cycle.
// Reset is asynchronous and active low; the buffers need no clearing after it.
// busy_o is high only while the front holds a request the full queue cannot take.

module idle_framed_receive_ring_top
  import ifrr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int unsigned RING_BYTES  = RING_BYTES_DEF,
  parameter int unsigned CMDQ_DEPTH  = CMDQ_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [BYTE_W-1:0]   rx_byte_i,
  input  logic [LIMIT_W-1:0]  read_limit_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   data_byte_o,
  output logic [FLEN_W-1:0]   frame_length_o,
  output logic                last_byte_o
);

  // The front end decodes each request into a command for the queue.
  cmd_t    front_cmd;
  logic    front_push;
  logic    queue_full;

  // The execution engine drains the queue one command at a time.
  cmd_t    queue_cmd;
  logic    queue_empty;
  logic    queue_pop;
  result_t result;

  ifrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .read_limit_i (read_limit_i),
    .busy_o       (busy_o),
    .full_i       (queue_full),
    .push_o       (front_push),
    .cmd_o        (front_cmd)
  );

  ifrr_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .cmd_o   (queue_cmd)
  );

  ifrr_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .RING_BYTES  (RING_BYTES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (queue_empty),
    .cmd_i   (queue_cmd),
    .pop_o   (queue_pop),
    .res_o   (result)
  );

  // Results come straight from the engine's output register.
  assign done_o         = result.done;
  assign status_o       = result.status;
  assign data_byte_o    = result.data_byte;
  assign frame_length_o = result.frame_length;
  assign last_byte_o    = result.last_byte;

endmodule

[hdl/ifrr_ram.sv]
module ifrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ifrr_front.sv]
module ifrr_front
  import ifrr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [BYTE_W-1:0]   rx_byte_i,
  input  logic [LIMIT_W-1:0]  read_limit_i,
  output logic                busy_o,
  input  logic                full_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  localparam logic [OPCODE_W-1:0] OP_RX_BYTE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LINE_IDLE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_OPEN      = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ      = 2'd3;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  cmd_t decoded;
  logic ready;
  logic accept;

  // Fields an operation does not use are zeroed so the back end sees clean requests.
  always_comb begin
    decoded = '0;
    unique case (opcode_i)
      OP_RX_BYTE: begin
        decoded.kind    = CMD_STORE;
        decoded.rx_byte = rx_byte_i;
      end
      OP_LINE_IDLE: begin
        decoded.kind = CMD_COMMIT;
      end
      OP_OPEN: begin
        decoded.kind       = CMD_OPEN;
        decoded.read_limit = read_limit_i;
      end
      OP_READ: begin
        decoded.kind = CMD_READ;
      end
    endcase
  end

  assign ready  = !valid_q || !full_i;
  assign accept = start_i && ready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (accept) begin
      valid_d = 1'b1;
      cmd_d   = decoded;
    end else if (valid_q && !full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign busy_o = !ready;
  assign push_o = valid_q;
  assign cmd_o  = cmd_q;

endmodule

[hdl/ifrr_cmdq.sv]
module ifrr_cmdq
  import ifrr_pkg::*;
#(
  parameter int unsigned DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t            entries_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hdl/ifrr_back.sv]
`include "idle_framed_receive_ring_top_assert.svh"

module ifrr_back
  import ifrr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int unsigned RING_BYTES  = RING_BYTES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    empty_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output result_t res_o
);

  localparam int unsigned FIW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned FCW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned RIW = $clog2(RING_BYTES);
  localparam int unsigned RCW = $clog2(RING_BYTES + 1);
  localparam int unsigned MW1 = (RCW > FCW) ? RCW : FCW;
  localparam int unsigned MW2 = (MW1 > LEN_W) ? MW1 : LEN_W;
  localparam int unsigned EW  = MW2 + 2;
  localparam int unsigned RRW = LIMIT_W;
  localparam int unsigned PEND_W = 11;
  localparam logic [PEND_W-1:0] PENDING_MAX = '1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_HDR_HI   = 3'd1;
  localparam logic [2:0] S_COPY     = 3'd2;
  localparam logic [2:0] S_OPEN_CHK = 3'd3;
  localparam logic [2:0] S_OPEN_LO  = 3'd4;
  localparam logic [2:0] S_OPEN_HI  = 3'd5;
  localparam logic [2:0] S_RD       = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [FCW-1:0]     fill_q, fill_d;
  logic [RIW-1:0]     head_q, head_d;
  logic [RIW-1:0]     tail_q, tail_d;
  logic [RCW-1:0]     count_q, count_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [RRW-1:0]     rr_q, rr_d;
  logic [FCW-1:0]     cp_idx_q, cp_idx_d;
  logic               cp_wr_q, cp_wr_d;
  logic [BYTE_W-1:0]  len_lo_q, len_lo_d;
  cmd_t               cmd_q, cmd_d;
  result_t            res_q, res_d;

  logic               f_we, f_re, r_we, r_re;
  logic [BYTE_W-1:0]  r_wdata;
  logic [BYTE_W-1:0]  frame_rd, ring_rd;

  logic [LEN_W-1:0]   fill16;
  logic               no_room;
  logic [RCW-1:0]     disc_n;
  logic [RCW:0]       disc_sum, disc_wrap;
  logic [LEN_W-1:0]   hdr_len;
  logic               hdr_bad;
  logic [RCW:0]       ptr_sum, head_ext;
  logic               ring_ptr_ok;

  function automatic logic [RIW-1:0] ring_inc(input logic [RIW-1:0] p);
    return (p == RIW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  ifrr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (fill_q[FIW-1:0]),
    .wdata_i (cmd_i.rx_byte),
    .re_i    (f_re),
    .raddr_i (cp_idx_q[FIW-1:0]),
    .rdata_o (frame_rd)
  );

  ifrr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (head_q),
    .wdata_i (r_wdata),
    .re_i    (r_re),
    .raddr_i (tail_q),
    .rdata_o (ring_rd)
  );

  assign fill16  = LEN_W'(fill_q);
  assign no_room = (EW'(count_q) + EW'(fill_q) + EW'(2)) > EW'(RING_BYTES);

  // Unread bytes of a frame still open are skipped before the next header.
  assign disc_n    = (EW'(rr_q) <= EW'(count_q)) ? RCW'(rr_q) : count_q;
  assign disc_sum  = (RCW + 1)'(tail_q) + (RCW + 1)'(disc_n);
  assign disc_wrap = (disc_sum >= (RCW + 1)'(RING_BYTES)) ?
                     disc_sum - (RCW + 1)'(RING_BYTES) : disc_sum;

  assign hdr_len = {ring_rd, len_lo_q};
  assign hdr_bad = (EW'(hdr_len) > EW'(cmd_q.read_limit)) ||
                   (EW'(count_q) < EW'(hdr_len));

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    pend_d   = pend_q;
    rr_d     = rr_q;
    cp_idx_d = cp_idx_q;
    cp_wr_d  = cp_wr_q;
    len_lo_d = len_lo_q;
    cmd_d    = cmd_q;
    res_d    = '0;
    f_we     = 1'b0;
    f_re     = 1'b0;
    r_we     = 1'b0;
    r_re     = 1'b0;
    r_wdata  = frame_rd;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          cmd_d = cmd_i;
          unique case (cmd_i.kind)
            CMD_STORE: begin
              res_d.done = 1'b1;
              if (fill_q < FCW'(FRAME_BYTES)) begin
                f_we         = 1'b1;
                fill_d       = fill_q + 1'b1;
                res_d.status = ST_STORED;
              end else begin
                res_d.status = ST_OVERFLOW;
              end
            end
            CMD_COMMIT: begin
              if (no_room) begin
                fill_d       = '0;
                res_d.done   = 1'b1;
                res_d.status = ST_DROPPED;
              end else begin
                r_we     = 1'b1;
                r_wdata  = fill16[7:0];
                head_d   = ring_inc(head_q);
                count_d  = count_q + 1'b1;
                cp_idx_d = '0;
                state_d  = S_HDR_HI;
              end
            end
            CMD_OPEN: begin
              if (pend_q == '0) begin
                res_d.done   = 1'b1;
                res_d.status = ST_NONE_PENDING;
              end else begin
                pend_d  = pend_q - 1'b1;
                tail_d  = disc_wrap[RIW-1:0];
                count_d = count_q - disc_n;
                rr_d    = '0;
                state_d = S_OPEN_CHK;
              end
            end
            CMD_READ: begin
              if (rr_q == '0 || count_q == '0) begin
                rr_d         = '0;
                res_d.done   = 1'b1;
                res_d.status = ST_NOTHING_OPEN;
              end else begin
                r_re    = 1'b1;
                tail_d  = ring_inc(tail_q);
                count_d = count_q - 1'b1;
                rr_d    = rr_q - 1'b1;
                state_d = S_RD;
              end
            end
          endcase
        end
      end

      S_HDR_HI: begin
        r_we    = 1'b1;
        r_wdata = fill16[15:8];
        head_d  = ring_inc(head_q);
        count_d = count_q + 1'b1;
        if (fill_q == '0) begin
          if (pend_q != PENDING_MAX) begin
            pend_d = pend_q + 1'b1;
          end
          res_d.done   = 1'b1;
          res_d.status = ST_COMMITTED;
          state_d      = S_IDLE;
        end else begin
          f_re     = 1'b1;
          cp_idx_d = cp_idx_q + 1'b1;
          cp_wr_d  = 1'b1;
          state_d  = S_COPY;
        end
      end

      // Each frame read is written to the ring in the cycle after it.
      S_COPY: begin
        if (cp_wr_q) begin
          r_we    = 1'b1;
          r_wdata = frame_rd;
          head_d  = ring_inc(head_q);
          count_d = count_q + 1'b1;
        end
        if (cp_idx_q < fill_q) begin
          f_re     = 1'b1;
          cp_idx_d = cp_idx_q + 1'b1;
          cp_wr_d  = 1'b1;
        end else begin
          cp_wr_d = 1'b0;
          fill_d  = '0;
          if (pend_q != PENDING_MAX) begin
            pend_d = pend_q + 1'b1;
          end
          res_d.done         = 1'b1;
          res_d.status       = ST_COMMITTED;
          res_d.frame_length = FLEN_W'(fill_q);
          state_d            = S_IDLE;
        end
      end

      S_OPEN_CHK: begin
        if (count_q < RCW'(2)) begin
          head_d       = '0;
          tail_d       = '0;
          count_d      = '0;
          rr_d         = '0;
          res_d.done   = 1'b1;
          res_d.status = ST_RING_RESET;
          state_d      = S_IDLE;
        end else begin
          r_re    = 1'b1;
          tail_d  = ring_inc(tail_q);
          count_d = count_q - 1'b1;
          state_d = S_OPEN_LO;
        end
      end

      S_OPEN_LO: begin
        len_lo_d = ring_rd;
        r_re     = 1'b1;
        tail_d   = ring_inc(tail_q);
        count_d  = count_q - 1'b1;
        state_d  = S_OPEN_HI;
      end

      S_OPEN_HI: begin
        res_d.done = 1'b1;
        if (hdr_bad) begin
          head_d       = '0;
          tail_d       = '0;
          count_d      = '0;
          rr_d         = '0;
          res_d.status = ST_RING_RESET;
        end else begin
          rr_d               = RRW'(hdr_len);
          res_d.status       = ST_OPENED;
          res_d.frame_length = hdr_len[FLEN_W-1:0];
        end
        state_d = S_IDLE;
      end

      S_RD: begin
        res_d.done      = 1'b1;
        res_d.status    = ST_DATA;
        res_d.data_byte = ring_rd;
        res_d.last_byte = (rr_q == '0);
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      pend_q   <= '0;
      rr_q     <= '0;
      cp_idx_q <= '0;
      cp_wr_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      rr_q     <= rr_d;
      cp_idx_q <= cp_idx_d;
      cp_wr_q  <= cp_wr_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_lo_q <= len_lo_d;
    cmd_q    <= cmd_d;
  end

  assign res_o = res_q;

  // The write pointer always sits count bytes past the read pointer.
  assign ptr_sum     = (RCW + 1)'(tail_q) + (RCW + 1)'(count_q);
  assign head_ext    = (RCW + 1)'(head_q);
  assign ring_ptr_ok = (ptr_sum == head_ext) ||
                       (ptr_sum == head_ext + (RCW + 1)'(RING_BYTES));

  `IFRR_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > RCW'(RING_BYTES),
                     "ring count exceeds ring size")
  `IFRR_ASSERT_NEVER(a_remaining_bound, clk_i, rst_ni, EW'(rr_q) > EW'(count_q),
                     "open frame claims more bytes than the ring holds")
  `IFRR_ASSERT_IMPL(a_ptr_consistent, clk_i, rst_ni, state_q != S_COPY || !cp_wr_q,
                    ring_ptr_ok, "ring pointers disagree with ring count")
  `IFRR_ASSERT_NEXT(a_read_result, clk_i, rst_ni, state_q == S_RD,
                    res_q.done && res_q.status == ST_DATA,
                    "read did not return a data result")

endmodule
